// File: sv/prvp_pkg.sv
package prvp_pkg;

   localparam int OP_W     = 2;
   localparam int FRAME_W  = 6;
   localparam int ROUND_W  = 2;
   localparam int POLICY_W = 2;
   localparam int FIU_W    = 7;
   localparam int LFSR_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
   localparam logic [LFSR_W-1:0] LFSR_RESET = 16'h0001;

   typedef enum logic [OP_W-1:0] {
      OP_READ    = 2'd0,
      OP_WRITE   = 2'd1,
      OP_INSTALL = 2'd2,
      OP_PICK    = 2'd3
   } op_type;

   localparam logic [POLICY_W-1:0] POL_FIFO   = 2'd0;
   localparam logic [POLICY_W-1:0] POL_CLOCK  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_RANDOM = 2'd2;
   localparam logic [POLICY_W-1:0] POL_RESET  = POL_CLOCK;

   localparam logic [FIU_W-1:0] FIU_RESET = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED   = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_RD,
      S_EV,
      S_DONE
   } state_type;

   function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
      logic [LFSR_W-1:0] r;
      r = v >> 1;
      if (v[0]) begin
         r = r ^ LFSR_TAPS;
      end
      return r;
   endfunction

endpackage

// File: sv/prvp_req_if.sv
interface prvp_req_if;
   import prvp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      operation;
   logic [FRAME_W-1:0]   frame;
   logic                 use_in;
   logic                 dirty_in;

   modport source (output valid, operation, frame, use_in, dirty_in, input ready);
   modport sink   (input valid, operation, frame, use_in, dirty_in, output ready);
endinterface

// File: sv/prvp_rsp_if.sv
interface prvp_rsp_if;
   import prvp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [FRAME_W-1:0]   victim_frame;
   logic                 victim_dirty;
   logic [ROUND_W-1:0]   search_round;

   modport source (output valid, victim_frame, victim_dirty, search_round, input ready);
   modport sink   (input valid, victim_frame, victim_dirty, search_round, output ready);
endinterface

// File: sv/prvp_ram.sv
module prvp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/prvp_mod.sv
module prvp_mod #(
   parameter int NUM_FRAMES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [prvp_pkg::LFSR_W-1:0]         dividend,
   input  logic [$clog2(NUM_FRAMES+1)-1:0]     divisor,
   output logic                                done,
   output logic [$clog2(NUM_FRAMES)-1:0]       remainder
);
   import prvp_pkg::*;

   localparam int IW  = $clog2(NUM_FRAMES);
   localparam int CW  = $clog2(NUM_FRAMES + 1);
   localparam int BCW = $clog2(LFSR_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [BCW-1:0]    bit_ff, bit_in;
   logic [LFSR_W-1:0] quo_ff, quo_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [CW-1:0]     div_ff, div_in;
   logic [CW:0]       trial;

   // restoring remainder, one dividend bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[LFSR_W-1]};
      if (start) begin
         busy_in = 1'b1;
         bit_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = CW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[CW-1:0];
         end
         quo_in = quo_ff << 1;
         bit_in = bit_ff + BCW'(1);
         if (bit_ff == BCW'(LFSR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff <= bit_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = IW'(rem_ff);

`ifndef SYNTHESIS
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |-> rem_ff < div_ff)
      else $error("remainder not below divisor");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("done without a running division");

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("division started while busy");
`endif
endmodule

// File: sv/page_replacement_victim_picker.sv
// Victim picker for page replacement. Keeps a use and a dirty bit per frame in two
// one-bit RAMs, a circular hand and a 16-bit LFSR. Read/write accesses and installs
// return nothing. A pick returns one result: fifo takes the frame at the hand,
// random starts the remainder unit, passes one LFSR bit per cycle through it, then
// reads a dirty bit, and the enhanced clock policy spends a RAM read, then a
// compare and optional use-bit clear, on each frame looked at; at most
// 3 * frame count + 1 frames are looked at. Only one item is in work at a time; a
// finished result waits in the output register while the next item is taken.
// After reset both RAMs are cleared, one frame per cycle, and no item is accepted
// meanwhile; configuration writes are taken at any time.
module page_replacement_victim_picker #(
   parameter int NUM_FRAMES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [prvp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [prvp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   prvp_req_if.sink                          req_ch,
   prvp_rsp_if.source                        rsp_ch
);
   import prvp_pkg::*;

   localparam int IW = $clog2(NUM_FRAMES);
   localparam int CW = $clog2(NUM_FRAMES + 1);

   state_type            state_ff, state_in;
   logic [POLICY_W-1:0]  policy_ff, policy_in;
   logic [FIU_W-1:0]     frames_ff, frames_in;
   logic [LFSR_W-1:0]    lfsr_ff, lfsr_in;
   logic [IW-1:0]        hand_ff, hand_in;
   logic [IW-1:0]        clr_ff, clr_in;
   logic [IW-1:0]        cur_ff, cur_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [ROUND_W-1:0]   round_ff, round_in;
   logic                 scan_ff, scan_in;
   logic                 hit_dirty_ff, hit_dirty_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]   rsp_frame_ff, rsp_frame_in;
   logic                 rsp_dirty_ff, rsp_dirty_in;
   logic [ROUND_W-1:0]   rsp_round_ff, rsp_round_in;

   logic                 req_xfer;
   op_type               op;
   logic                 frame_ok;
   logic [IW-1:0]        frame_idx;
   logic [CW-1:0]        n_eff;
   logic [IW-1:0]        start_idx;
   logic [IW-1:0]        start_nxt;
   logic [IW-1:0]        cur_nxt;
   logic [CW-1:0]        cnt_nxt;
   logic [LFSR_W-1:0]    lfsr_adv;
   logic                 hit;
   logic                 slot_free;

   logic                 use_we, dirty_we;
   logic [IW-1:0]        use_waddr, dirty_waddr;
   logic                 use_wdata, dirty_wdata;
   logic                 use_rd, dirty_rd;

   logic                 mod_start, mod_done;
   logic                 mod_go_ff, mod_go_in;
   logic [IW-1:0]        mod_rem;

   prvp_ram #(.WIDTH(1), .DEPTH(NUM_FRAMES)) u_use_ram (
      .clock   (clock),
      .we      (use_we),
      .wr_addr (use_waddr),
      .wr_data (use_wdata),
      .rd_addr (cur_ff),
      .rd_data (use_rd)
   );

   prvp_ram #(.WIDTH(1), .DEPTH(NUM_FRAMES)) u_dirty_ram (
      .clock   (clock),
      .we      (dirty_we),
      .wr_addr (dirty_waddr),
      .wr_data (dirty_wdata),
      .rd_addr (cur_ff),
      .rd_data (dirty_rd)
   );

   prvp_mod #(.NUM_FRAMES(NUM_FRAMES)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (lfsr_adv),
      .divisor   (n_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign op           = op_type'(req_ch.operation);
   assign frame_ok     = (32'(req_ch.frame) < NUM_FRAMES);
   assign frame_idx    = IW'(req_ch.frame);
   assign lfsr_adv     = lfsr_ff;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   // clamp frame count into 1..NUM_FRAMES
   always_comb begin
      if (frames_ff == '0) begin
         n_eff = CW'(1);
      end else if (32'(frames_ff) > NUM_FRAMES) begin
         n_eff = CW'(NUM_FRAMES);
      end else begin
         n_eff = CW'(frames_ff);
      end
   end

   assign start_idx = (CW'(hand_ff) < n_eff) ? hand_ff : '0;
   assign start_nxt = (CW'(start_idx) + CW'(1) == n_eff) ? '0 : start_idx + IW'(1);
   assign cur_nxt   = (CW'(cur_ff) + CW'(1) == n_ff) ? '0 : cur_ff + IW'(1);
   assign cnt_nxt   = cnt_ff + CW'(1);
   assign hit       = !use_rd && (dirty_rd == round_ff[0]);

   always_comb begin
      state_in     = state_ff;
      policy_in    = policy_ff;
      frames_in    = frames_ff;
      lfsr_in      = lfsr_ff;
      hand_in      = hand_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      round_in     = round_ff;
      scan_in      = scan_ff;
      hit_dirty_in = hit_dirty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_frame_in = rsp_frame_ff;
      rsp_dirty_in = rsp_dirty_ff;
      rsp_round_in = rsp_round_ff;
      use_we       = 1'b0;
      use_waddr    = frame_idx;
      use_wdata    = 1'b1;
      dirty_we     = 1'b0;
      dirty_waddr  = frame_idx;
      dirty_wdata  = 1'b1;
      mod_start    = 1'b0;
      mod_go_in    = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            use_we      = 1'b1;
            use_waddr   = clr_ff;
            use_wdata   = 1'b0;
            dirty_we    = 1'b1;
            dirty_waddr = clr_ff;
            dirty_wdata = 1'b0;
            clr_in      = clr_ff + IW'(1);
            if (32'(clr_ff) == NUM_FRAMES - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               unique case (op)
                  OP_READ: begin
                     use_we = frame_ok;
                  end
                  OP_WRITE: begin
                     use_we   = frame_ok;
                     dirty_we = frame_ok;
                  end
                  OP_INSTALL: begin
                     use_we      = frame_ok;
                     use_wdata   = req_ch.use_in;
                     dirty_we    = frame_ok;
                     dirty_wdata = req_ch.dirty_in;
                  end
                  OP_PICK: begin
                     n_in     = n_eff;
                     round_in = '0;
                     cnt_in   = '0;
                     if (policy_ff == POL_RANDOM) begin
                        lfsr_in   = lfsr_step(lfsr_ff);
                        scan_in   = 1'b0;
                        mod_go_in = 1'b1;
                        state_in  = S_MOD;
                     end else if (policy_ff == POL_CLOCK) begin
                        cur_in   = start_idx;
                        scan_in  = 1'b1;
                        state_in = S_RD;
                     end else begin
                        cur_in   = start_idx;
                        hand_in  = start_nxt;
                        scan_in  = 1'b0;
                        state_in = S_RD;
                     end
                  end
               endcase
            end
         end
         S_MOD: begin
            // divisor n_ff is loaded at accept, kick the unit on entry
            mod_start = mod_go_ff;
            if (mod_done) begin
               cur_in   = mod_rem;
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_EV;
         end
         S_EV: begin
            if (!scan_ff || hit) begin
               hit_dirty_in = dirty_rd;
               if (scan_ff) begin
                  hand_in = cur_nxt;
               end
               state_in = S_DONE;
            end else begin
               // second pass drops the use bit of every frame it skips
               if (round_ff == ROUND_W'(1)) begin
                  use_we    = 1'b1;
                  use_waddr = cur_ff;
                  use_wdata = 1'b0;
               end
               cur_in = cur_nxt;
               if (cnt_nxt == n_ff) begin
                  cnt_in   = '0;
                  round_in = round_ff + ROUND_W'(1);
               end else begin
                  cnt_in = cnt_nxt;
               end
               state_in = S_RD;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_frame_in = FRAME_W'(cur_ff);
               rsp_dirty_in = hit_dirty_ff;
               rsp_round_in = round_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         if (csr_index == CSR_POLICY) begin
            policy_in = csr_wdata[POLICY_W-1:0];
         end else if (csr_index == CSR_FRAMES) begin
            frames_in = csr_wdata[FIU_W-1:0];
         end else if (csr_index == CSR_SEED) begin
            lfsr_in = (csr_wdata[LFSR_W-1:0] == '0) ? LFSR_RESET : csr_wdata[LFSR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         policy_ff    <= POL_RESET;
         frames_ff    <= FIU_RESET;
         lfsr_ff      <= LFSR_RESET;
         hand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         mod_go_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         policy_ff    <= policy_in;
         frames_ff    <= frames_in;
         lfsr_ff      <= lfsr_in;
         hand_ff      <= hand_in;
         rsp_valid_ff <= rsp_valid_in;
         mod_go_ff    <= mod_go_in;
      end
      cur_ff       <= cur_in;
      cnt_ff       <= cnt_in;
      n_ff         <= n_in;
      round_ff     <= round_in;
      scan_ff      <= scan_in;
      hit_dirty_ff <= hit_dirty_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_dirty_ff <= rsp_dirty_in;
      rsp_round_ff <= rsp_round_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.victim_frame = rsp_frame_ff;
   assign rsp_ch.victim_dirty = rsp_dirty_ff;
   assign rsp_ch.search_round = rsp_round_ff;

`ifndef SYNTHESIS
   a_scan_count_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EV |-> (cnt_ff < n_ff) && (CW'(cur_ff) < n_ff))
      else $error("scan position outside frame count");

   a_last_pass_hits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EV && scan_ff && round_ff == ROUND_W'(3) && cnt_nxt == n_ff |-> hit)
      else $error("clock search ran out of frames");

   a_pick_blocks_input: assert property (@(posedge clock) disable iff (reset)
      req_xfer && op == OP_PICK |=> !req_ch.ready)
      else $error("input taken while a pick is in work");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside the done state");
`endif
endmodule

// File: dv/tb.sv
module tb;
   import prvp_pkg::*;

   localparam int FRAMES_MAX  = 64;
   localparam int QUIET_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 20;

   // policy code with no policy of its own, behaves as fifo
   localparam logic [POLICY_W-1:0] POL_UNUSED = 2'd3;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic               dirty;
      logic [ROUND_W-1:0] search_round;
   } victim_type;

   class victim_scoreboard;
      bit                  use_bits[FRAMES_MAX];
      bit                  dirty_bits[FRAMES_MAX];
      int                  hand;
      logic [LFSR_W-1:0]   lfsr;
      logic [POLICY_W-1:0] policy;
      logic [FIU_W-1:0]    frames_in_use;
      victim_type          pending_victims[$];
      int                  errors;

      function new();
         policy = POL_RESET;
         frames_in_use = FIU_RESET;
         lfsr = LFSR_RESET;
         hand = 0;
         errors = 0;
         foreach (use_bits[i]) begin
            use_bits[i] = 0;
            dirty_bits[i] = 0;
         end
      endfunction

      function int frame_span();
         if (frames_in_use == 0) return 1;
         if (frames_in_use > FRAMES_MAX) return FRAMES_MAX;
         return int'(frames_in_use);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_POLICY: policy = data[POLICY_W-1:0];
            CSR_FRAMES: frames_in_use = data[FIU_W-1:0];
            CSR_SEED:   lfsr = (data == 0) ? LFSR_RESET : data;
            default: ;
         endcase
      endfunction

      function victim_type pick_victim();
         victim_type v;
         int      n;
         int      start;
         int      idx;
         bit      found;
         n = frame_span();
         start = (hand < n) ? hand : 0;
         v = '0;
         found = 0;
         if (policy == POL_RANDOM) begin
            lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
            v.frame = FRAME_W'(int'(lfsr) % n);
         end else if (policy == POL_CLOCK) begin
            // pass 1 clears use bits it walks over, so pass 2 or 3 always hits
            for (int r = 0; r < 4 && !found; r++) begin
               for (int k = 0; k < n && !found; k++) begin
                  idx = (start + k) % n;
                  if (!use_bits[idx] && dirty_bits[idx] == r[0]) begin
                     v.frame = FRAME_W'(idx);
                     v.search_round = ROUND_W'(r);
                     found = 1;
                  end else if (r == 1) begin
                     use_bits[idx] = 0;
                  end
               end
            end
            hand = (int'(v.frame) + 1) % n;
         end else begin
            // fifo, and the unused policy code as well
            v.frame = FRAME_W'(start);
            hand = (start + 1) % n;
         end
         v.dirty = dirty_bits[v.frame];
         return v;
      endfunction

      function void note_request(op_type op, logic [FRAME_W-1:0] fr, logic u, logic d);
         case (op)
            OP_READ: use_bits[fr] = 1;
            OP_WRITE: begin
               use_bits[fr] = 1;
               dirty_bits[fr] = 1;
            end
            OP_INSTALL: begin
               use_bits[fr] = u;
               dirty_bits[fr] = d;
            end
            default: pending_victims.push_back(pick_victim());
         endcase
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_victim(logic [FRAME_W-1:0] fr, logic d, logic [ROUND_W-1:0] rnd);
         victim_type want;
         if (pending_victims.size() == 0) begin
            report($sformatf("victim %0d with no pick outstanding", fr));
         end else begin
            want = pending_victims.pop_front();
            if (fr !== want.frame)
               report($sformatf("victim_frame got %0d want %0d", fr, want.frame));
            if (d !== want.dirty)
               report($sformatf("victim_dirty got %0d want %0d", d, want.dirty));
            if (rnd !== want.search_round)
               report($sformatf("search_round got %0d want %0d", rnd, want.search_round));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   prvp_req_if req_ch();
   prvp_rsp_if rsp_ch();

   page_replacement_victim_picker #(.NUM_FRAMES(FRAMES_MAX)) uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source)
   );

   victim_scoreboard sb = new();

   int req_idle_pct;
   int rsp_idle_pct;
   int rsp_hold;
   int quiet_cycles;

   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // result side: random stalls, or a counted hold-off
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ch.ready <= 0;
         rsp_hold--;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_victim(rsp_ch.victim_frame, rsp_ch.victim_dirty, rsp_ch.search_round);
         if (req_ch.valid && req_ch.ready)
            sb.note_request(op_type'(req_ch.operation), req_ch.frame, req_ch.use_in,
                            req_ch.dirty_in);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("page_replacement_victim_picker verification failed");
            $finish;
         end
      end
   end

   task send_request(op_type op, logic [FRAME_W-1:0] fr, logic u, logic d);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 0;
         @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.operation <= op;
      req_ch.frame <= fr;
      req_ch.use_in <= u;
      req_ch.dirty_in <= d;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task pick();
      send_request(OP_PICK, FRAME_W'($urandom_range(63)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
   endtask

   // hold the input until all picks are answered and the last access is done
   task drain();
      req_ch.valid <= 0;
      while (sb.pending_victims.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_we <= 0;
      @(negedge clock);
   endtask

   task send_random();
      int     roll;
      int     n;
      op_type op;
      logic [FRAME_W-1:0] fr;
      roll = $urandom_range(99);
      if (roll < 35) op = OP_READ;
      else if (roll < 58) op = OP_WRITE;
      else if (roll < 75) op = OP_INSTALL;
      else op = OP_PICK;
      n = sb.frame_span();
      // mostly frames inside the active window so the clock search has work
      if ($urandom_range(99) < 80) fr = FRAME_W'($urandom_range(n - 1, 0));
      else fr = FRAME_W'($urandom_range(FRAMES_MAX - 1, 0));
      send_request(op, fr, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task run_phase(logic [POLICY_W-1:0] pol, int frames, int seed, int count, bit hold);
      drain();
      write_csr(CSR_POLICY, CSR_DATA_W'(pol));
      write_csr(CSR_FRAMES, CSR_DATA_W'(frames));
      write_csr(CSR_SEED, CSR_DATA_W'(seed));
      if (hold) rsp_hold = 400;
      repeat (count) send_random();
   endtask

   initial begin
      reset = 1;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 0;
      req_ch.operation = '0;
      req_ch.frame = '0;
      req_ch.use_in = 0;
      req_ch.dirty_in = 0;
      rsp_ch.ready = 0;
      req_idle_pct = 25;
      rsp_idle_pct = 78;
      rsp_hold = 0;
      quiet_cycles = 0;
      repeat (12) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // clock policy on four frames: one pick per search pass
      write_csr(CSR_FRAMES, 16'd4);
      pick();
      for (int i = 0; i < 4; i++) send_request(OP_WRITE, FRAME_W'(i), 1'b0, 1'b0);
      pick();
      for (int i = 0; i < 4; i++) send_request(OP_READ, FRAME_W'(i), 1'b1, 1'b1);
      send_request(OP_INSTALL, 6'd2, 1'b1, 1'b0);
      pick();
      send_request(OP_WRITE, 6'd2, 1'b0, 1'b0);
      pick();
      // top frame lies outside the window but is still updated
      send_request(OP_INSTALL, 6'd63, 1'b1, 1'b1);
      send_request(OP_READ, 6'd63, 1'b0, 1'b0);
      send_request(OP_INSTALL, 6'd63, 1'b0, 1'b0);

      drain();
      write_csr(CSR_POLICY, CSR_DATA_W'(POL_FIFO));
      write_csr(CSR_FRAMES, 16'd64);
      pick();
      pick();
      // frame count zero acts as one, and the hand is past it
      drain();
      write_csr(CSR_FRAMES, 16'd0);
      pick();
      drain();
      write_csr(CSR_POLICY, CSR_DATA_W'(POL_UNUSED));
      write_csr(CSR_FRAMES, 16'd127);
      pick();
      drain();
      write_csr(CSR_POLICY, CSR_DATA_W'(POL_RANDOM));
      write_csr(CSR_SEED, 16'd0);
      pick();
      pick();
      drain();
      write_csr(CSR_SEED, 16'hFFFF);
      write_csr(CSR_FRAMES, 16'd64);
      pick();

      run_phase(POL_CLOCK, 8, 16'hACE1, 85, 1'b0);
      run_phase(POL_FIFO, 64, 16'h0001, 85, 1'b0);
      run_phase(POL_RANDOM, 13, 16'hFFFF, 85, 1'b0);
      run_phase(POL_CLOCK, 64, 16'h1234, 85, 1'b0);

      req_idle_pct = 78;
      rsp_idle_pct = 25;
      run_phase(POL_CLOCK, 3, 16'h8000, 85, 1'b0);
      run_phase(POL_RANDOM, 64, 16'h0001, 85, 1'b0);
      run_phase(POL_UNUSED, 5, 16'h5A5A, 85, 1'b0);
      run_phase(POL_CLOCK, 1, 16'h0F0F, 85, 1'b0);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_phase(POL_CLOCK, 16, 16'hBEEF, 85, 1'b1);
      run_phase(POL_RANDOM, 2, 16'h7FFF, 85, 1'b0);
      run_phase(POL_FIFO, 2, 16'h0002, 85, 1'b0);
      run_phase(POL_CLOCK, 127, 16'hC0DE, 85, 1'b0);

      drain();
      if (sb.errors == 0)
         $display("page_replacement_victim_picker verification clean");
      else
         $display("page_replacement_victim_picker verification failed");
      $finish;
   end

endmodule
